// ----- rtl/core/tte_pkg.sv -----
// Shared types and constants for the LED twinkle envelope engine.
`timescale 1ns / 1ps

package tte_pkg;

	localparam int LED_COUNT = 64;
	localparam int IDX_W     = 6;
	localparam int LEVEL_W   = 8;
	localparam int COUNT_W   = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_RISE  = 2'd1,
		PH_FALL  = 2'd2,
		PH_END   = 2'd3
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_STARS = 2'd0,
		REG_PEAK      = 2'd1,
		REG_RISE_STEP = 2'd2,
		REG_FALL_STEP = 2'd3
	} cfg_reg_t;

	localparam logic [COUNT_W-1:0] MAX_STARS_RST = 7'd20;
	localparam logic [LEVEL_W-1:0] PEAK_RST      = 8'd50;
	localparam logic [LEVEL_W-1:0] RISE_STEP_RST = 8'd2;
	localparam logic [LEVEL_W-1:0] FALL_STEP_RST = 8'd1;

	// State of one LED as it travels around the ring.
	typedef struct packed {
		phase_t              phase;
		logic [LEVEL_W-1:0]  level;
		logic                free;
	} cell_t;

	localparam cell_t CELL_RST = '{phase: PH_START, level: '0, free: 1'b1};

	typedef struct packed {
		logic [LEVEL_W-1:0] peak;
		logic [LEVEL_W-1:0] rise_step;
		logic [LEVEL_W-1:0] fall_step;
	} env_cfg_t;

	// Count adjustments reported by the update unit for one LED.
	typedef struct packed {
		logic inc;
		logic dec;
	} count_adj_t;

endpackage

// ----- rtl/core/tte_cell.sv -----
// One storage cell of the LED state ring.
`timescale 1ns / 1ps

module tte_cell
	import tte_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift_en,
	input  cell_t d,
	output cell_t q
);

	cell_t cell_q;

	// Take the neighbor's state on every shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= CELL_RST;
		end else if (shift_en) begin
			cell_q <= d;
		end
	end

	assign q = cell_q;

endmodule

// ----- rtl/core/tte_led_update.sv -----
// Claim, free and envelope step for the LED at the head of the ring.
`timescale 1ns / 1ps

module tte_led_update
	import tte_pkg::*;
(
	input  cell_t      cur,
	input  logic       claim_hit,
	input  env_cfg_t   cfg,
	output cell_t      nxt,
	output count_adj_t adj
);

	cell_t              stepped;
	logic [LEVEL_W:0]   rise_sum;

	assign rise_sum = {1'b0, cur.level} + {1'b0, cfg.rise_step};

	always_comb begin
		stepped = cur;
		unique case (cur.phase)
			PH_START: begin
				stepped.level = '0;
				stepped.phase = PH_RISE;
			end
			PH_RISE: begin
				if (rise_sum >= {1'b0, cfg.peak}) begin
					stepped.level = cfg.peak;
					stepped.phase = PH_FALL;
				end else begin
					stepped.level = rise_sum[LEVEL_W-1:0];
				end
			end
			PH_FALL: begin
				if (cur.level <= cfg.fall_step) begin
					stepped.level = '0;
					stepped.phase = PH_END;
				end else begin
					stepped.level = cur.level - cfg.fall_step;
				end
			end
			PH_END: begin
				stepped.level = '0;
				stepped.phase = PH_START;
			end
			default: begin
				stepped.level = '0;
				stepped.phase = PH_START;
			end
		endcase
	end

	always_comb begin
		nxt = cur;
		adj = '0;
		priority if (claim_hit && cur.free) begin
			nxt      = stepped;
			nxt.free = 1'b0;
			adj.inc  = 1'b1;
		end else if (!cur.free) begin
			nxt = stepped;
			if (cur.phase == PH_END) begin
				nxt.free = 1'b1;
				adj.dec  = 1'b1;
			end
		end else begin
			nxt = cur;
		end
	end

endmodule

// ----- rtl/core/led_twinkle_envelope_engine.sv -----
// Top level of the LED twinkle envelope engine: control, ring and result register.
`timescale 1ns / 1ps

// Each input beat is one animation tick carrying a candidate LED index. The
// per-LED state (phase, level, free flag) lives in a ring of LED_COUNT cells
// that rotates by one position per cycle while a tick runs and the output
// register is not stalled; the cell at the head goes through one shared
// update unit (claim, free, envelope step) and its result beat is loaded into
// the output register. A tick rotates the ring once through all LED_COUNT
// cells (64 by default). The block takes a new tick once the ring is back in
// order, even while the final result beat still waits. The star-limit test
// uses the active count as it stands when the tick is accepted. Beats come
// out in LED order, with last set on LED LED_COUNT-1. All state is cleared
// by reset; no clearing pass is needed. Configuration writes land immediately
// and must only be made while the block is idle.
module led_twinkle_envelope_engine
	import tte_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [IDX_W-1:0]     candidate_led,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [IDX_W-1:0]     led_index,
	output logic [LEVEL_W-1:0]   level,
	output logic                 last,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t               state_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     cand_q;
	logic                 offer_q;
	logic [COUNT_W-1:0]   active_count_q;
	logic                 out_valid_q;
	logic [IDX_W-1:0]     led_index_q;
	logic [LEVEL_W-1:0]   level_q;
	logic                 last_q;

	logic [COUNT_W-1:0]   max_stars_q;
	env_cfg_t             env_cfg_q;

	cell_t                ring [LED_COUNT];
	cell_t                head_nxt;
	count_adj_t           adj;
	logic                 advance;
	logic                 claim_hit;
	logic                 in_accept;
	logic                 offer;
	logic                 idx_last;
	logic [LED_COUNT-1:0] free_vec;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_stars_q         <= MAX_STARS_RST;
			env_cfg_q.peak      <= PEAK_RST;
			env_cfg_q.rise_step <= RISE_STEP_RST;
			env_cfg_q.fall_step <= FALL_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MAX_STARS: max_stars_q         <= cfg_data[COUNT_W-1:0];
				REG_PEAK:      env_cfg_q.peak      <= cfg_data;
				REG_RISE_STEP: env_cfg_q.rise_step <= cfg_data;
				REG_FALL_STEP: env_cfg_q.fall_step <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	// Star limit and range check, decided once per tick.
	assign offer = (active_count_q < max_stars_q)
		&& ({1'b0, candidate_led} < COUNT_W'(LED_COUNT));

	// Move one LED per cycle while the result register can take a beat.
	assign advance   = (state_q == ST_RUN) && (!out_valid_q || !out_stall);
	assign claim_hit = offer_q && (idx_q == cand_q);
	assign idx_last  = (idx_q == IDX_W'(LED_COUNT - 1));

	tte_led_update u_update (
		.cur       (ring[0]),
		.claim_hit (claim_hit),
		.cfg       (env_cfg_q),
		.nxt       (head_nxt),
		.adj       (adj)
	);

	// The ring: each cell takes its upper neighbor, the tail takes the head's update.
	for (genvar k = 0; k < LED_COUNT; k++) begin : g_ring
		if (k == LED_COUNT - 1) begin : g_tail
			tte_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (advance),
				.d        (head_nxt),
				.q        (ring[k])
			);
		end else begin : g_body
			tte_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (advance),
				.d        (ring[k+1]),
				.q        (ring[k])
			);
		end
		assign free_vec[k] = ring[k].free;
	end

	// Sequencer, active count and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			idx_q          <= '0;
			cand_q         <= '0;
			offer_q        <= 1'b0;
			active_count_q <= '0;
			out_valid_q    <= 1'b0;
			led_index_q    <= '0;
			level_q        <= '0;
			last_q         <= 1'b0;
		end else begin
			// Drop the result beat once taken, unless a new one replaces it.
			if (out_valid_q && !out_stall && !advance) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						cand_q  <= candidate_led;
						offer_q <= offer;
						idx_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (advance) begin
						out_valid_q    <= 1'b1;
						led_index_q    <= idx_q;
						level_q        <= head_nxt.free ? '0 : head_nxt.level;
						last_q         <= idx_last;
						active_count_q <= active_count_q
							+ COUNT_W'(adj.inc) - COUNT_W'(adj.dec);
						idx_q          <= idx_q + 1'b1;
						if (idx_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign led_index = led_index_q;
	assign level     = level_q;
	assign last      = last_q;

	// Active count always matches the number of claimed cells in the ring.
	a_count_matches_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(COUNT_W'(LED_COUNT) - COUNT_W'($countones(free_vec))) == active_count_q)
		else $error("active count disagrees with ring contents");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		active_count_q <= COUNT_W'(LED_COUNT))
		else $error("active count above LED count");

	// A free LED has always been parked at start with a dark level.
	a_free_is_parked: assert property (@(posedge clk) disable iff (!arst_n)
		ring[0].free |-> (ring[0].level == '0 && ring[0].phase == PH_START))
		else $error("free LED holds envelope state");

	a_last_on_final_led: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && idx_last) |=> (out_valid_q && last_q && state_q == ST_IDLE))
		else $error("final LED beat not flagged at end of tick");

endmodule

// ----- tb/twinkle_level_checker.sv -----
// Watches the tick and level channels, predicts every level beat and compares it.
`timescale 1ns / 1ps

module twinkle_level_checker
	import tte_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [IDX_W-1:0]     candidate_led,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [IDX_W-1:0]     led_index,
	input  logic [LEVEL_W-1:0]   level,
	input  logic                 last,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output int                   backlog,
	output int                   mismatches
);

	typedef struct {
		logic [IDX_W-1:0]   led;
		logic [LEVEL_W-1:0] lvl;
		logic               tail;
	} level_beat_t;

	level_beat_t        expected_levels[$];

	phase_t             star_phase[LED_COUNT];
	logic [LEVEL_W-1:0] star_level[LED_COUNT];
	logic               star_free[LED_COUNT];
	logic [COUNT_W-1:0] lit_count;

	logic [COUNT_W-1:0] star_limit;
	logic [LEVEL_W-1:0] peak_level;
	logic [LEVEL_W-1:0] rise_inc;
	logic [LEVEL_W-1:0] fall_dec;

	initial begin
		backlog    = 0;
		mismatches = 0;
	end

	function automatic void clear_stars();
		for (int i = 0; i < LED_COUNT; i++) begin
			star_phase[i] = PH_START;
			star_level[i] = '0;
			star_free[i]  = 1'b1;
		end
		lit_count  = '0;
		star_limit = MAX_STARS_RST;
		peak_level = PEAK_RST;
		rise_inc   = RISE_STEP_RST;
		fall_dec   = FALL_STEP_RST;
		expected_levels.delete();
	endfunction

	// One envelope step of one LED.
	function automatic void step_star(input int i);
		logic [LEVEL_W:0] sum;
		case (star_phase[i])
			PH_START: begin
				star_level[i] = '0;
				star_phase[i] = PH_RISE;
			end
			PH_RISE: begin
				sum = {1'b0, star_level[i]} + {1'b0, rise_inc};
				if (sum >= {1'b0, peak_level}) begin
					star_level[i] = peak_level;
					star_phase[i] = PH_FALL;
				end else begin
					star_level[i] = sum[LEVEL_W-1:0];
				end
			end
			PH_FALL: begin
				if (star_level[i] <= fall_dec) begin
					star_level[i] = '0;
					star_phase[i] = PH_END;
				end else begin
					star_level[i] = star_level[i] - fall_dec;
				end
			end
			default: begin
				star_level[i] = '0;
				star_phase[i] = PH_START;
			end
		endcase
	endfunction

	// Claim, free and step the lit LEDs for one tick; queue a level beat for every LED.
	function automatic void predict_tick(input logic [IDX_W-1:0] cand);
		logic        offer;
		level_beat_t beat;
		offer = (lit_count < star_limit) && (int'(cand) < LED_COUNT);
		for (int i = 0; i < LED_COUNT; i++) begin
			if (offer && int'(cand) == i && star_free[i]) begin
				star_free[i] = 1'b0;
				lit_count    = lit_count + 1'b1;
				step_star(i);
			end else if (!star_free[i]) begin
				if (star_phase[i] == PH_END) begin
					lit_count    = lit_count - 1'b1;
					star_free[i] = 1'b1;
				end
				step_star(i);
			end
			beat.led  = IDX_W'(i);
			beat.lvl  = star_free[i] ? '0 : star_level[i];
			beat.tail = (i == LED_COUNT - 1);
			expected_levels.push_back(beat);
		end
	endfunction

	always @(posedge clk) begin
		level_beat_t want;
		if (!arst_n) begin
			clear_stars();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_MAX_STARS: star_limit = cfg_data[COUNT_W-1:0];
					REG_PEAK:      peak_level = cfg_data[LEVEL_W-1:0];
					REG_RISE_STEP: rise_inc   = cfg_data[LEVEL_W-1:0];
					REG_FALL_STEP: fall_dec   = cfg_data[LEVEL_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_tick(candidate_led);
			if (out_valid && !out_stall) begin
				if (expected_levels.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: level beat with nothing expected: %s %0d %0d %0b",
							$time, "led/level/last", led_index, level, last);
					mismatches++;
				end else begin
					want = expected_levels.pop_front();
					if (led_index !== want.led || level !== want.lvl
						|| last !== want.tail) begin
						if (mismatches < 10)
							$display({"%0t: level beat mismatch: expected led %0d ",
								"level %0d last %0b, got led %0d level %0d last %0b"},
								$time, want.led, want.lvl, want.tail,
								led_index, level, last);
						mismatches++;
					end
				end
			end
		end
		backlog <= expected_levels.size();
	end

endmodule

// ----- tb/led_twinkle_envelope_engine_test.sv -----
// Stimulus and verdict for the LED twinkle envelope engine.
`timescale 1ns / 1ps

module led_twinkle_envelope_engine_test;
	import tte_pkg::*;

	localparam int IDLE_PCT     = 36;    // percent of cycles each side idles
	localparam int HOLD_CYCLES  = 700;   // long output hold-off
	localparam int STALL_LIMIT  = 8000;  // cycles without any beat before giving up
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_TICKS  = 45;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 in_valid      = 1'b0;
	logic                 in_stall;
	logic [IDX_W-1:0]     candidate_led = '0;
	logic                 out_valid;
	logic                 out_stall     = 1'b0;
	logic [IDX_W-1:0]     led_index;
	logic [LEVEL_W-1:0]   level;
	logic                 last;
	logic                 cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [CFG_DAT_W-1:0] cfg_data      = '0;

	int backlog;
	int mismatches;

	// Calm turns off idling on both sides; hold_off asks the receiver for one long stall.
	logic calm     = 1'b0;
	logic hold_off = 1'b0;
	int   hold_left = 0;
	int   quiet_cycles = 0;

	always #4 clk = ~clk;

	led_twinkle_envelope_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.candidate_led (candidate_led),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.led_index     (led_index),
		.level         (level),
		.last          (last),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	twinkle_level_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.candidate_led (candidate_led),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.led_index     (led_index),
		.level         (level),
		.last          (last),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.backlog       (backlog),
		.mismatches    (mismatches)
	);

	// Receiver: stall at random, or hold off for a long counted stretch when asked.
	always @(posedge clk) begin
		if (hold_off) begin
			hold_off  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Watchdog: count cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Offer one tick beat, after a random idle gap, and hold it until accepted.
	task automatic send_tick(input logic [IDX_W-1:0] cand);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		candidate_led <= cand;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop valid and wait until every level beat of the last tick has come out.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (backlog != 0)
			@(posedge clk);
		repeat (LED_COUNT + 4) @(posedge clk);
	endtask

	// Drain, then write all four registers back to back with the write enable held.
	task automatic load_settings(input logic [CFG_DAT_W-1:0] stars, bright, rise, fall);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_MAX_STARS;
		cfg_data  <= stars;
		@(posedge clk);
		cfg_index <= REG_PEAK;
		cfg_data  <= bright;
		@(posedge clk);
		cfg_index <= REG_RISE_STEP;
		cfg_data  <= rise;
		@(posedge clk);
		cfg_index <= REG_FALL_STEP;
		cfg_data  <= fall;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		logic [CFG_DAT_W-1:0] stars, bright, rise, fall;
		logic [IDX_W-1:0]     cand;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: lowest and highest LED, a repeat claim of a busy LED.
		send_tick(6'd0);
		send_tick(6'd63);
		send_tick(6'd0);
		send_tick(6'd5);
		send_tick(6'd63);
		send_tick(6'h2a);

		// Top extremes: every LED allowed, full peak, full steps; a single rise step reaches the top.
		load_settings(8'd64, 8'd255, 8'd255, 8'd255);
		send_tick(6'd10);
		send_tick(6'h15);
		send_tick(6'd10);
		send_tick(6'd11);

		// Zero peak: a rising LED drops straight to zero and starts to fall.
		load_settings(8'd20, 8'd0, 8'd2, 8'd1);
		send_tick(6'd20);
		send_tick(6'd21);
		send_tick(6'd22);

		// Zero rise step: rising LEDs stay put.
		load_settings(8'd20, 8'd50, 8'd0, 8'd1);
		send_tick(6'd23);
		send_tick(6'd24);
		send_tick(6'd25);

		// Zero fall step: falling LEDs hang at their level.
		load_settings(8'd20, 8'd50, 8'd60, 8'd0);
		send_tick(6'd26);
		send_tick(6'd27);
		send_tick(6'd28);

		// Star limit of zero: every candidate is ignored.
		load_settings(8'd0, 8'd50, 8'd2, 8'd1);
		send_tick(6'd30);
		send_tick(6'd31);

		// Random phases, each with its own settings.
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: begin
					stars = 8'd64; bright = 8'd255; rise = 8'd1; fall = 8'd1;
				end
				1: begin
					stars = 8'd1; bright = 8'd1; rise = 8'd255; fall = 8'd255;
				end
				default: begin
					stars  = CFG_DAT_W'($urandom_range(64));
					bright = CFG_DAT_W'(($urandom_range(3) == 0)
						? $urandom_range(255, 1) : $urandom_range(16, 1));
					rise   = CFG_DAT_W'(($urandom_range(1) == 0)
						? $urandom_range(8, 1) : $urandom_range(255, 1));
					fall   = CFG_DAT_W'(($urandom_range(1) == 0)
						? $urandom_range(8, 1) : $urandom_range(255, 1));
				end
			endcase
			load_settings(stars, bright, rise, fall);
			calm = (p == 3);
			for (int t = 0; t < PHASE_TICKS; t++) begin
				// Ask for the long hold-off once; keep offering ticks so the input backs up.
				if (p == 5 && t == 3)
					hold_off = 1'b1;
				// Crowd a quarter of the candidates onto a few LEDs to hit busy ones.
				if ($urandom_range(3) == 0)
					cand = IDX_W'($urandom_range(7));
				else
					cand = IDX_W'($urandom_range(LED_COUNT - 1));
				send_tick(cand);
			end
		end
		calm = 1'b0;

		drain();
		repeat (2 * LED_COUNT) @(posedge clk);
		if (mismatches == 0 && backlog == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
